FILE: design/httprlp_pkg.sv
// Shared types, character constants and helpers for the request-line parser.
`timescale 1ns / 1ps

package httprlp_pkg;

   localparam int BUF_SIZE_DEF = 8192;
   localparam int OFFSET_W     = 13;
   localparam int VERSION_W    = 10;
   localparam logic [VERSION_W-1:0] VERSION_MAX = 10'd999;

   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_SPACE = " ";
   localparam logic [7:0] CH_SLASH = "/";
   localparam logic [7:0] CH_DOT   = ".";
   localparam logic [7:0] CH_UNDER = "_";
   localparam logic [7:0] CH_H     = "H";
   localparam logic [7:0] CH_T     = "T";
   localparam logic [7:0] CH_P     = "P";
   localparam logic [7:0] CH_A     = "A";
   localparam logic [7:0] CH_Z     = "Z";
   localparam logic [7:0] CH_0     = "0";
   localparam logic [7:0] CH_1     = "1";
   localparam logic [7:0] CH_9     = "9";

   localparam logic [23:0] MTH_GET  = "GET";
   localparam logic [31:0] MTH_HEAD = "HEAD";
   localparam logic [31:0] MTH_POST = "POST";

   typedef enum logic [3:0] {
      PH_START   = 4'd0,
      PH_METHOD  = 4'd1,
      PH_SP_URI  = 4'd2,
      PH_URI     = 4'd3,
      PH_HTTP    = 4'd4,
      PH_H       = 4'd5,
      PH_HT      = 4'd6,
      PH_HTT     = 4'd7,
      PH_HTTP_SL = 4'd8,
      PH_MAJ1    = 4'd9,
      PH_MAJ     = 4'd10,
      PH_MIN1    = 4'd11,
      PH_MIN     = 4'd12,
      PH_SP_END  = 4'd13,
      PH_ALMOST  = 4'd14
   } phase_type;

   typedef enum logic [1:0] {
      ST_AGAIN     = 2'd0,
      ST_DONE      = 2'd1,
      ST_BADMETHOD = 2'd2,
      ST_BADREQ    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      MTH_UNKNOWN = 2'd0,
      MTH_IS_GET  = 2'd1,
      MTH_IS_HEAD = 2'd2,
      MTH_IS_POST = 2'd3
   } method_type;

   typedef struct packed {
      logic [OFFSET_W-1:0]  line_stop_offset;
      logic [OFFSET_W-1:0]  path_stop_offset;
      logic [OFFSET_W-1:0]  path_start_offset;
      logic [OFFSET_W-1:0]  method_stop_offset;
      logic [OFFSET_W-1:0]  line_start_offset;
      logic [VERSION_W-1:0] version_minor;
      logic [VERSION_W-1:0] version_major;
      method_type           method_code;
      status_type           status;
   } result_type;

   function automatic logic is_method_char(input logic [7:0] c);
      return ((c >= CH_A) && (c <= CH_Z)) || (c == CH_UNDER);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_0) && (c <= CH_9);
   endfunction

   // v*10 + digit as shifts and adds, clamped to 999
   function automatic logic [VERSION_W-1:0] acc_digit(input logic [VERSION_W-1:0] v,
                                                      input logic [7:0] c);
      logic [VERSION_W+3:0] n;
      n = {v, 3'b000} + {3'b000, v, 1'b0} + (VERSION_W+4)'(c - CH_0);
      return (n > (VERSION_W+4)'(VERSION_MAX)) ? VERSION_MAX : n[VERSION_W-1:0];
   endfunction

endpackage

FILE: design/http_request_line_parser.sv
// HTTP/1.x request-line parser: one request byte in, one status/offset item out.
// An accepted byte's result item appears on rsp_* in the cycle after it is accepted.
// Throughput: 1 byte per cycle unless rsp_* stalls; the output register drains and reloads together.
// A stall on rsp_tready holds req_tready low while the result register is full.
// Reset (synchronous, active high): start phase, byte offset, method, versions and
// saved offsets cleared; no result item pending.
`timescale 1ns / 1ps

module http_request_line_parser
   import httprlp_pkg::*;
#(
   parameter int BUF_SIZE = BUF_SIZE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [1:0] status, [3:2] method_code, [13:4] version_major, [23:14] version_minor,
   // [36:24] line_start_offset, [49:37] method_stop_offset,
   // [62:50] path_start_offset, [75:63] path_stop_offset,
   // [88:76] line_stop_offset, [95:89] zero
   output logic [95:0] rsp_tdata
);

   logic       accept;
   result_type result;

   httprlp_core #(
      .BUF_SIZE (BUF_SIZE)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .in_accept (accept),
      .data_byte (req_tdata),
      .result    (result)
   );

   httprlp_obuf u_obuf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_accept (accept),
      .result    (result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata)
   );

endmodule

FILE: design/httprlp_core.sv
// Parser state registers and the per-byte phase transition logic.
`timescale 1ns / 1ps

module httprlp_core
   import httprlp_pkg::*;
#(
   parameter int BUF_SIZE = BUF_SIZE_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_accept,
   input  logic [7:0] data_byte,
   output result_type result
);

   localparam int OFF_W = $clog2(BUF_SIZE);
   localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(BUF_SIZE - 1);

   phase_type            phase_ff, phase_in;
   logic [OFF_W-1:0]     off_ff, off_in;
   logic [31:0]          chars_ff, chars_in;
   logic [2:0]           len_ff, len_in;
   method_type           kind_ff, kind_in;
   logic [VERSION_W-1:0] major_ff, major_in;
   logic [VERSION_W-1:0] minor_ff, minor_in;
   logic [OFFSET_W-1:0]  line_start_ff, line_start_in;
   logic [OFFSET_W-1:0]  method_stop_ff, method_stop_in;
   logic [OFFSET_W-1:0]  path_start_ff, path_start_in;
   logic [OFFSET_W-1:0]  path_stop_ff, path_stop_in;
   logic [OFFSET_W-1:0]  line_stop_ff, line_stop_in;
   status_type           status;

   logic [31:0]          off_wide;
   logic [31:0]          prev_wide;
   logic [OFFSET_W-1:0]  off_out;
   logic [OFFSET_W-1:0]  prev_out;
   method_type           kind_class;

   // offsets are reported as the low bits of the ring position
   assign off_wide  = 32'(off_ff);
   assign prev_wide = (off_ff == '0) ? 32'(OFF_LAST) : 32'(off_ff - 1'b1);
   assign off_out   = off_wide[OFFSET_W-1:0];
   assign prev_out  = prev_wide[OFFSET_W-1:0];

   always_comb begin
      kind_class = MTH_UNKNOWN;
      if (len_ff == 3'd3) begin
         if (chars_ff[23:0] == MTH_GET) kind_class = MTH_IS_GET;
      end else if (len_ff == 3'd4) begin
         if (chars_ff == MTH_POST) kind_class = MTH_IS_POST;
         else if (chars_ff == MTH_HEAD) kind_class = MTH_IS_HEAD;
      end
   end

   always_comb begin
      phase_in       = phase_ff;
      chars_in       = chars_ff;
      len_in         = len_ff;
      kind_in        = kind_ff;
      major_in       = major_ff;
      minor_in       = minor_ff;
      line_start_in  = line_start_ff;
      method_stop_in = method_stop_ff;
      path_start_in  = path_start_ff;
      path_stop_in   = path_stop_ff;
      line_stop_in   = line_stop_ff;
      status         = ST_AGAIN;

      case (phase_ff)
         PH_START: begin
            line_start_in = off_out;
            if ((data_byte == CH_CR) || (data_byte == CH_LF)) begin
               phase_in = PH_START;
            end else if (!is_method_char(data_byte)) begin
               status = ST_BADMETHOD;
            end else begin
               // first method byte opens a new line
               chars_in       = {24'd0, data_byte};
               len_in         = 3'd1;
               kind_in        = MTH_UNKNOWN;
               major_in       = '0;
               minor_in       = '0;
               method_stop_in = '0;
               path_start_in  = '0;
               path_stop_in   = '0;
               line_stop_in   = '0;
               phase_in       = PH_METHOD;
            end
         end
         PH_METHOD: begin
            if (data_byte == CH_SPACE) begin
               method_stop_in = off_out;
               kind_in        = kind_class;
               phase_in       = PH_SP_URI;
            end else if (is_method_char(data_byte)) begin
               chars_in = {chars_ff[23:0], data_byte};
               if (len_ff != 3'd7) len_in = len_ff + 3'd1;
            end else begin
               status = ST_BADMETHOD;
            end
         end
         PH_SP_URI: begin
            if (data_byte == CH_SLASH) begin
               path_start_in = off_out;
               phase_in      = PH_URI;
            end else if (data_byte != CH_SPACE) begin
               status = ST_BADREQ;
            end
         end
         PH_URI: begin
            if (data_byte == CH_SPACE) begin
               path_stop_in = off_out;
               phase_in     = PH_HTTP;
            end
         end
         PH_HTTP: begin
            if (data_byte == CH_H) phase_in = PH_H;
            else if (data_byte != CH_SPACE) status = ST_BADREQ;
         end
         PH_H: begin
            if (data_byte == CH_T) phase_in = PH_HT;
            else status = ST_BADREQ;
         end
         PH_HT: begin
            if (data_byte == CH_T) phase_in = PH_HTT;
            else status = ST_BADREQ;
         end
         PH_HTT: begin
            if (data_byte == CH_P) phase_in = PH_HTTP_SL;
            else status = ST_BADREQ;
         end
         PH_HTTP_SL: begin
            if (data_byte == CH_SLASH) phase_in = PH_MAJ1;
            else status = ST_BADREQ;
         end
         PH_MAJ1: begin
            if ((data_byte >= CH_1) && (data_byte <= CH_9)) begin
               major_in = VERSION_W'(data_byte - CH_0);
               phase_in = PH_MAJ;
            end else begin
               status = ST_BADREQ;
            end
         end
         PH_MAJ: begin
            if (data_byte == CH_DOT) phase_in = PH_MIN1;
            else if (is_digit(data_byte)) major_in = acc_digit(major_ff, data_byte);
            else status = ST_BADREQ;
         end
         PH_MIN1: begin
            if (is_digit(data_byte)) begin
               minor_in = VERSION_W'(data_byte - CH_0);
               phase_in = PH_MIN;
            end else begin
               status = ST_BADREQ;
            end
         end
         PH_MIN: begin
            if (data_byte == CH_CR) begin
               phase_in = PH_ALMOST;
            end else if (data_byte == CH_LF) begin
               line_stop_in = off_out;
               status       = ST_DONE;
            end else if (data_byte == CH_SPACE) begin
               phase_in = PH_SP_END;
            end else if (is_digit(data_byte)) begin
               minor_in = acc_digit(minor_ff, data_byte);
            end else begin
               status = ST_BADREQ;
            end
         end
         PH_SP_END: begin
            if (data_byte == CH_CR) begin
               phase_in = PH_ALMOST;
            end else if (data_byte == CH_LF) begin
               line_stop_in = off_out;
               status       = ST_DONE;
            end else if (data_byte != CH_SPACE) begin
               status = ST_BADREQ;
            end
         end
         PH_ALMOST: begin
            // line ends at the CR one byte back
            line_stop_in = prev_out;
            status       = (data_byte == CH_LF) ? ST_DONE : ST_BADREQ;
         end
         default: begin
            phase_in = PH_START;
         end
      endcase

      if (status != ST_AGAIN) phase_in = PH_START;
   end

   assign off_in = (off_ff == OFF_LAST) ? '0 : off_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_START;
         off_ff         <= '0;
         chars_ff       <= '0;
         len_ff         <= '0;
         kind_ff        <= MTH_UNKNOWN;
         major_ff       <= '0;
         minor_ff       <= '0;
         line_start_ff  <= '0;
         method_stop_ff <= '0;
         path_start_ff  <= '0;
         path_stop_ff   <= '0;
         line_stop_ff   <= '0;
      end else if (in_accept) begin
         phase_ff       <= phase_in;
         off_ff         <= off_in;
         chars_ff       <= chars_in;
         len_ff         <= len_in;
         kind_ff        <= kind_in;
         major_ff       <= major_in;
         minor_ff       <= minor_in;
         line_start_ff  <= line_start_in;
         method_stop_ff <= method_stop_in;
         path_start_ff  <= path_start_in;
         path_stop_ff   <= path_stop_in;
         line_stop_ff   <= line_stop_in;
      end
   end

   assign result.status             = status;
   assign result.method_code        = kind_in;
   assign result.version_major      = major_in;
   assign result.version_minor      = minor_in;
   assign result.line_start_offset  = line_start_in;
   assign result.method_stop_offset = method_stop_in;
   assign result.path_start_offset  = path_start_in;
   assign result.path_stop_offset   = path_stop_in;
   assign result.line_stop_offset   = line_stop_in;

   a_restart_after_end: assert property (@(posedge clock) disable iff (reset)
      in_accept && (status != ST_AGAIN) |=> phase_ff == PH_START)
      else $error("parser did not restart after done or error");

   a_offset_wrap: assert property (@(posedge clock) disable iff (reset)
      in_accept && (off_ff == OFF_LAST) |=> off_ff == '0)
      else $error("byte offset did not wrap");

   a_offset_step: assert property (@(posedge clock) disable iff (reset)
      in_accept && (off_ff != OFF_LAST) |=> off_ff == OFF_W'($past(off_ff) + 1'b1))
      else $error("byte offset did not advance by one");

   a_version_sat: assert property (@(posedge clock) disable iff (reset)
      (major_ff <= VERSION_MAX) && (minor_ff <= VERSION_MAX))
      else $error("version above saturation limit");

endmodule

FILE: design/httprlp_obuf.sv
// Result register with handshake: holds one result item, loads while draining.
`timescale 1ns / 1ps

module httprlp_obuf
   import httprlp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   output logic        in_accept,
   input  result_type  result,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [95:0] out_data
);

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign in_ready  = !valid_ff || out_ready;
   assign in_accept = in_valid && in_ready;
   assign valid_in  = in_accept || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept) begin
         data_ff <= result;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = {7'd0, data_ff};

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !out_ready |-> !in_accept)
      else $error("held item overwritten");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      in_accept |=> valid_ff)
      else $error("accepted item not presented");

   a_drain_clears: assert property (@(posedge clock) disable iff (reset)
      valid_ff && out_ready && !in_accept |=> !valid_ff)
      else $error("taken item still presented");

endmodule
